/* design/bdtc_pkg.sv */
// Shared types, constants, microcode ROM and helpers for the boundary-tag heap free block.
// No dependencies; every other design file uses it by scoped names.
`default_nettype none
package bdtc_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int TAG_BYTES  = 16;
    localparam int ADDR_W     = $clog2(HEAP_BYTES);
    localparam int TAG_LG     = $clog2(TAG_BYTES);
    localparam int TAG_SLOTS  = HEAP_BYTES / TAG_BYTES;
    localparam int SLOT_W     = ADDR_W - TAG_LG;
    localparam int SIZE_W     = 16;
    localparam int STEP_W     = 5;

    localparam logic [ADDR_W-1:0] TAG_OFS  = ADDR_W'(TAG_BYTES);
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [STEP_W-1:0] step_t;

    // item modes
    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_RES  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        addr_t      addr;
        size_t      prev_size_in;
        size_t      next_size_in;
        logic       reserved_in;
        size_t      add_bytes;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        size_t      tag_prev_size;
        size_t      tag_next_size;
        logic       tag_reserved;
        size_t      freed_bytes;
        size_t      bytes_in_use;
    } out_t;

    typedef struct packed {
        logic  res;
        size_t next;
        size_t prev;
    } tag_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        tag_t              wdata;
    } mem_req_t;

    // condition flags of the last tag read
    typedef struct packed {
        logic res;
        logic next_zero;
        logic prev_zero;
    } flags_t;

    typedef enum logic [1:0] {
        AS_IN = 2'd0,
        AS_T  = 2'd1,
        AS_NX = 2'd2,
        AS_PV = 2'd3
    } addr_sel_t;

    typedef enum logic [1:0] {
        WOP_PUT    = 2'd0,
        WOP_PREV   = 2'd1,
        WOP_NEXT   = 2'd2,
        WOP_CLRRES = 2'd3
    } wr_op_t;

    typedef enum logic [3:0] {
        DP_NONE      = 4'd0,
        DP_TAKE_SIZE = 4'd1,
        DP_CHECK     = 4'd2,
        DP_MERGE     = 4'd3,
        DP_PV_ADDR   = 4'd4,
        DP_ABSORB    = 4'd5,
        DP_READ_OUT  = 4'd6,
        DP_ADD_USE   = 4'd7,
        DP_ERR       = 4'd8
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_NOT_RES   = 3'd1,
        C_NO_MERGE  = 3'd2,
        C_PREV_ZERO = 3'd3,
        C_RES       = 3'd4
    } cond_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      rd_en;
        logic      wr_en;
        wr_op_t    wr_op;
        dp_op_t    dp_op;
        cond_t     cond;
        step_t     target;
        logic      done;
    } ucode_t;

    // program addresses
    localparam step_t S_F_RD_T    = step_t'(0);
    localparam step_t S_F_CHK_RES = step_t'(1);
    localparam step_t S_F_SIZE    = step_t'(2);
    localparam step_t S_F_RD_NX   = step_t'(3);
    localparam step_t S_F_CHK_NX  = step_t'(4);
    localparam step_t S_F_MERGE   = step_t'(5);
    localparam step_t S_F_WR_T    = step_t'(6);
    localparam step_t S_F_RD_NX2  = step_t'(7);
    localparam step_t S_F_WR_NX2  = step_t'(8);
    localparam step_t S_F_RD_T2   = step_t'(9);
    localparam step_t S_F_PSIZE   = step_t'(10);
    localparam step_t S_F_RD_PV   = step_t'(11);
    localparam step_t S_F_ABSORB  = step_t'(12);
    localparam step_t S_F_WR_PV   = step_t'(13);
    localparam step_t S_F_RD_NX3  = step_t'(14);
    localparam step_t S_F_WR_NX3  = step_t'(15);
    localparam step_t S_F_RD_T3   = step_t'(16);
    localparam step_t S_F_CLR     = step_t'(17);
    localparam step_t S_F_ERR     = step_t'(18);
    localparam step_t S_W_PUT     = step_t'(19);
    localparam step_t S_R_RD      = step_t'(20);
    localparam step_t S_R_OUT     = step_t'(21);
    localparam step_t S_NOP       = step_t'(22);

    function automatic ucode_t uc(addr_sel_t a, logic rd, logic wr, wr_op_t w,
                                  dp_op_t d, cond_t c, step_t tgt, logic dn);
        ucode_t u;
        u.addr_sel = a;
        u.rd_en    = rd;
        u.wr_en    = wr;
        u.wr_op    = w;
        u.dp_op    = d;
        u.cond     = c;
        u.target   = tgt;
        u.done     = dn;
        return u;
    endfunction

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t u;
        unique case (s)
            S_F_RD_T:    u = uc(AS_T,  1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_CHK_RES: u = uc(AS_T,  1'b0, 1'b0, WOP_PUT,    DP_NONE,      C_NOT_RES,   S_F_ERR, 1'b0);
            S_F_SIZE:    u = uc(AS_T,  1'b0, 1'b0, WOP_PUT,    DP_TAKE_SIZE, C_NEXT,      S_NOP, 1'b0);
            S_F_RD_NX:   u = uc(AS_NX, 1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_CHK_NX:  u = uc(AS_NX, 1'b0, 1'b0, WOP_PUT,    DP_CHECK,     C_NO_MERGE,  S_F_RD_NX2, 1'b0);
            S_F_MERGE:   u = uc(AS_T,  1'b1, 1'b0, WOP_PUT,    DP_MERGE,     C_NEXT,      S_NOP, 1'b0);
            S_F_WR_T:    u = uc(AS_T,  1'b0, 1'b1, WOP_NEXT,   DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_RD_NX2:  u = uc(AS_NX, 1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_WR_NX2:  u = uc(AS_NX, 1'b0, 1'b1, WOP_PREV,   DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_RD_T2:   u = uc(AS_T,  1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_PSIZE:   u = uc(AS_T,  1'b0, 1'b0, WOP_PUT,    DP_PV_ADDR,   C_PREV_ZERO, S_F_RD_T3, 1'b0);
            S_F_RD_PV:   u = uc(AS_PV, 1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_ABSORB:  u = uc(AS_PV, 1'b0, 1'b0, WOP_PUT,    DP_ABSORB,    C_RES,       S_F_RD_T3, 1'b0);
            S_F_WR_PV:   u = uc(AS_PV, 1'b0, 1'b1, WOP_NEXT,   DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_RD_NX3:  u = uc(AS_NX, 1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_WR_NX3:  u = uc(AS_NX, 1'b0, 1'b1, WOP_PREV,   DP_NONE,      C_NEXT,      S_NOP, 1'b1);
            S_F_RD_T3:   u = uc(AS_T,  1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_F_CLR:     u = uc(AS_T,  1'b0, 1'b1, WOP_CLRRES, DP_NONE,      C_NEXT,      S_NOP, 1'b1);
            S_F_ERR:     u = uc(AS_T,  1'b0, 1'b0, WOP_PUT,    DP_ERR,       C_NEXT,      S_NOP, 1'b1);
            S_W_PUT:     u = uc(AS_IN, 1'b0, 1'b1, WOP_PUT,    DP_ADD_USE,   C_NEXT,      S_NOP, 1'b1);
            S_R_RD:      u = uc(AS_IN, 1'b1, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b0);
            S_R_OUT:     u = uc(AS_IN, 1'b0, 1'b0, WOP_PUT,    DP_READ_OUT,  C_NEXT,      S_NOP, 1'b1);
            default:     u = uc(AS_IN, 1'b0, 1'b0, WOP_PUT,    DP_NONE,      C_NEXT,      S_NOP, 1'b1);
        endcase
        return u;
    endfunction

    function automatic step_t entry_of(logic [1:0] mode);
        step_t s;
        unique case (mode)
            MODE_FREE:  s = S_F_RD_T;
            MODE_WRITE: s = S_W_PUT;
            MODE_READ:  s = S_R_RD;
            default:    s = S_NOP;
        endcase
        return s;
    endfunction

    // a + b + one tag, clamped to the size range
    function automatic size_t sat_add_tag(size_t a, size_t b);
        logic [SIZE_W+1:0] s;
        s = {2'b00, a} + {2'b00, b} + (SIZE_W+2)'(TAG_BYTES);
        return (s[SIZE_W+1:SIZE_W] != 2'b00) ? SIZE_MAX : s[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* design/bdtc_tag_mem.sv */
// Tag store: one tag per slot, one access per cycle, registered read data.
// Depends on bdtc_pkg.
`default_nettype none
module bdtc_tag_mem (
    input  wire logic              aclk,
    input  wire bdtc_pkg::mem_req_t req,
    output bdtc_pkg::tag_t          rdata
);

    bdtc_pkg::tag_t mem [bdtc_pkg::TAG_SLOTS];
    bdtc_pkg::tag_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.slot] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.slot];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/bdtc_seq.sv */
// Microcode sequencer: step counter, ROM fetch, conditional jumps, result stall.
// Depends on bdtc_pkg.
`default_nettype none
module bdtc_seq (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [1:0]       start_mode,
    input  wire bdtc_pkg::flags_t flags,
    input  wire logic             out_stall,
    output logic                  busy,
    output bdtc_pkg::ucode_t      cw
);

    logic                  busy_reg, busy_next;
    bdtc_pkg::step_t       step_reg, step_next;
    bdtc_pkg::ucode_t      rom_word;
    logic                  cond_hit;
    logic                  go;

    assign rom_word = bdtc_pkg::ucode_rom(step_reg);

    always_comb begin
        unique case (rom_word.cond)
            bdtc_pkg::C_NOT_RES:   cond_hit = !flags.res;
            bdtc_pkg::C_NO_MERGE:  cond_hit = flags.res || flags.next_zero;
            bdtc_pkg::C_PREV_ZERO: cond_hit = flags.prev_zero;
            bdtc_pkg::C_RES:       cond_hit = flags.res;
            default:               cond_hit = 1'b0;
        endcase
    end

    // a finishing step waits while the output register is full and not being taken
    assign go = busy_reg && !(rom_word.done && out_stall);

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = bdtc_pkg::entry_of(start_mode);
        end else if (go) begin
            if (rom_word.done) begin
                busy_next = 1'b0;
            end else if (cond_hit) begin
                step_next = rom_word.target;
            end else begin
                step_next = step_reg + bdtc_pkg::step_t'(1);
            end
        end
    end

    always_comb begin
        cw = rom_word;
        if (!go) begin
            cw.rd_en = 1'b0;
            cw.wr_en = 1'b0;
            cw.dp_op = bdtc_pkg::DP_NONE;
            cw.done  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

/* design/bdtc_datapath.sv */
// Datapath: item registers, tag address and size arithmetic, result fields.
// Driven by the control word of bdtc_seq; depends on bdtc_pkg.
`default_nettype none
module bdtc_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire bdtc_pkg::in_t    s_word,
    input  wire bdtc_pkg::ucode_t cw,
    input  wire bdtc_pkg::tag_t   rdata,
    output bdtc_pkg::mem_req_t    req,
    output bdtc_pkg::flags_t      flags,
    output bdtc_pkg::out_t        res_next
);

    bdtc_pkg::in_t   in_reg;
    bdtc_pkg::addr_t t_addr_reg, t_addr_next;
    bdtc_pkg::addr_t nx_addr_reg, nx_addr_next;
    bdtc_pkg::addr_t pv_addr_reg, pv_addr_next;
    bdtc_pkg::size_t tnext_reg, tnext_next;
    bdtc_pkg::out_t  out_reg, out_next;
    bdtc_pkg::addr_t byte_addr;
    logic [bdtc_pkg::SIZE_W:0] use_sum;

    assign flags.res       = rdata.res;
    assign flags.next_zero = (rdata.next == '0);
    assign flags.prev_zero = (rdata.prev == '0);

    always_comb begin
        unique case (cw.addr_sel)
            bdtc_pkg::AS_IN: byte_addr = in_reg.addr;
            bdtc_pkg::AS_T:  byte_addr = t_addr_reg;
            bdtc_pkg::AS_NX: byte_addr = nx_addr_reg;
            default:         byte_addr = pv_addr_reg;
        endcase
    end

    always_comb begin
        req.rd_en = cw.rd_en;
        req.wr_en = cw.wr_en;
        req.slot  = byte_addr[bdtc_pkg::ADDR_W-1:bdtc_pkg::TAG_LG];
        req.wdata = rdata;
        unique case (cw.wr_op)
            bdtc_pkg::WOP_PUT: begin
                req.wdata.res  = in_reg.reserved_in;
                req.wdata.next = in_reg.next_size_in;
                req.wdata.prev = in_reg.prev_size_in;
            end
            bdtc_pkg::WOP_PREV: req.wdata.prev = tnext_reg;
            bdtc_pkg::WOP_NEXT: req.wdata.next = tnext_reg;
            default:            req.wdata.res  = 1'b0;
        endcase
    end

    assign use_sum = {1'b0, out_reg.bytes_in_use} + {1'b0, in_reg.add_bytes};

    always_comb begin
        t_addr_next  = t_addr_reg;
        nx_addr_next = nx_addr_reg;
        pv_addr_next = pv_addr_reg;
        tnext_next   = tnext_reg;
        out_next     = out_reg;
        if (start) begin
            // payload sits one tag above its tag; wraps round the heap
            t_addr_next            = s_word.addr - bdtc_pkg::TAG_OFS;
            out_next.status        = bdtc_pkg::ST_OK;
            out_next.tag_prev_size = '0;
            out_next.tag_next_size = '0;
            out_next.tag_reserved  = 1'b0;
            out_next.freed_bytes   = '0;
        end else begin
            unique case (cw.dp_op)
                bdtc_pkg::DP_TAKE_SIZE: begin
                    tnext_next           = rdata.next;
                    out_next.freed_bytes = rdata.next;
                    out_next.bytes_in_use = (out_reg.bytes_in_use > rdata.next) ?
                        out_reg.bytes_in_use - rdata.next : '0;
                    nx_addr_next = t_addr_reg + rdata.next + bdtc_pkg::TAG_OFS;
                end
                bdtc_pkg::DP_CHECK: begin
                    if (rdata.prev != tnext_reg) begin
                        out_next.status = bdtc_pkg::ST_MISMATCH;
                    end
                end
                bdtc_pkg::DP_MERGE: begin
                    tnext_next   = bdtc_pkg::sat_add_tag(tnext_reg, rdata.next);
                    nx_addr_next = nx_addr_reg + rdata.next + bdtc_pkg::TAG_OFS;
                end
                bdtc_pkg::DP_PV_ADDR: begin
                    pv_addr_next = t_addr_reg - rdata.prev - bdtc_pkg::TAG_OFS;
                end
                bdtc_pkg::DP_ABSORB: begin
                    tnext_next = bdtc_pkg::sat_add_tag(rdata.next, tnext_reg);
                end
                bdtc_pkg::DP_READ_OUT: begin
                    out_next.tag_prev_size = rdata.prev;
                    out_next.tag_next_size = rdata.next;
                    out_next.tag_reserved  = rdata.res;
                end
                bdtc_pkg::DP_ADD_USE: begin
                    out_next.bytes_in_use = use_sum[bdtc_pkg::SIZE_W] ?
                        bdtc_pkg::SIZE_MAX : use_sum[bdtc_pkg::SIZE_W-1:0];
                end
                bdtc_pkg::DP_ERR: begin
                    out_next.status = bdtc_pkg::ST_NOT_RES;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            in_reg <= s_word;
        end
        t_addr_reg  <= t_addr_next;
        nx_addr_reg <= nx_addr_next;
        pv_addr_reg <= pv_addr_next;
        tnext_reg   <= tnext_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else begin
            out_reg <= out_next;
        end
    end

    assign res_next = out_next;

endmodule
`default_nettype wire

/* design/boundary_tag_free_coalesce.sv */
// Top level of the boundary-tag heap free block: handshakes and output register.
// Instantiates bdtc_seq, bdtc_datapath and bdtc_tag_mem; depends on bdtc_pkg.
//
//  channel  | ports                    | word
//  ---------+--------------------------+------------------------------------
//  input    | s_valid s_ready s_data   | mode, addr, sizes, flag, add_bytes
//  result   | m_valid m_ready m_data   | status, tag fields, freed, in use
//
// A word runs as a microprogram over the single-port tag store, at most one
// access a cycle; a free whose tag is not reserved ends with the not-reserved status.
// s_ready is high whenever no program runs; a new word may be taken while the
// previous result still sits in the output register. The last step of a program
// waits while that register is full and m_ready is low. Reset clears control and
// the in-use count; the tag store is not cleared.
`default_nettype none
module boundary_tag_free_coalesce (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bdtc_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bdtc_pkg::out_t      m_data
);

    logic               busy;
    logic               start;
    logic               out_stall;
    bdtc_pkg::ucode_t   cw;
    bdtc_pkg::flags_t   flags;
    bdtc_pkg::mem_req_t req;
    bdtc_pkg::tag_t     rdata;
    bdtc_pkg::out_t     res_next;
    logic               m_valid_reg;
    bdtc_pkg::out_t     m_data_reg;

    assign s_ready   = !busy;
    assign start     = s_valid && s_ready;
    assign out_stall = m_valid_reg && !m_ready;

    bdtc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .start_mode (s_data.mode),
        .flags      (flags),
        .out_stall  (out_stall),
        .busy       (busy),
        .cw         (cw)
    );

    bdtc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .s_word   (s_data),
        .cw       (cw),
        .rdata    (rdata),
        .req      (req),
        .flags    (flags),
        .res_next (res_next)
    );

    bdtc_tag_mem u_mem (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cw.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cw.done) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
